[rtl/brhp_pkg.sv]
// shared types, constants and helpers for the byte range header parser
package brhp_pkg;

    // default and port widths of the offset values
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int OUT_VALUE_WIDTH = 64;
    localparam int CHAR_WIDTH      = 8;

    // prefix "bytes=" length and the special characters
    localparam logic [2:0]            PREFIX_LEN = 3'd6;
    localparam logic [CHAR_WIDTH-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;

    // result status codes
    typedef enum logic [1:0] {
        ST_MISSING = 2'd0,
        ST_INVALID = 2'd1,
        ST_VALID   = 2'd2
    } t_status;

    // result detail codes, in order of priority after empty
    typedef enum logic [3:0] {
        DT_OK        = 4'd0,
        DT_EMPTY     = 4'd1,
        DT_NOT_BYTES = 4'd2,
        DT_MULTIPLE  = 4'd3,
        DT_NO_DASH   = 4'd4,
        DT_SUFFIX    = 4'd5,
        DT_BAD_START = 4'd6,
        DT_BAD_END   = 4'd7,
        DT_END_LT    = 4'd8
    } t_detail;

    // one input word as held in the input register
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] char_byte;
        logic                  byte_present;
        logic                  last;
    } t_in_word;

    // verdict handed from the parser core to the result register
    typedef struct packed {
        t_status status;
        t_detail detail;
        logic    end_present;
    } t_verdict;

    // expected prefix character at a given position
    function automatic logic [CHAR_WIDTH-1:0] prefix_char(input logic [2:0] idx);
        logic [CHAR_WIDTH-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h62; // b
            3'd1:    ch = 8'h79; // y
            3'd2:    ch = 8'h74; // t
            3'd3:    ch = 8'h65; // e
            3'd4:    ch = 8'h73; // s
            3'd5:    ch = 8'h3D; // =
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/brhp_dec_acc.sv]
// decimal accumulate step: value * 10 + digit with overflow detect
module brhp_dec_acc #(
    parameter int VALUE_WIDTH = brhp_pkg::VALUE_WIDTH_DEF
) (
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [3:0]             i_digit,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_ovf
);

    localparam int WideW = VALUE_WIDTH + 4;

    logic [WideW-1:0] w_wide;

    // times ten as shift-add, plus the digit; top nibble flags overflow
    assign w_wide  = (WideW'(i_value) << 3) + (WideW'(i_value) << 1) + WideW'(i_digit);
    assign o_value = w_wide[VALUE_WIDTH-1:0];
    assign o_ovf   = |w_wide[WideW-1:VALUE_WIDTH];

endmodule

[rtl/brhp_parse_core.sv]
// parser state, per-character update and end-of-header verdict
module brhp_parse_core #(
    parameter int VALUE_WIDTH = brhp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  brhp_pkg::t_in_word       i_word,
    output brhp_pkg::t_verdict       o_verdict,
    output logic [VALUE_WIDTH-1:0]   o_range_start,
    output logic [VALUE_WIDTH-1:0]   o_range_end
);

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_START  = 2'd1,
        PH_END    = 2'd2
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_prefix_index, n_prefix_index;
    logic [VALUE_WIDTH-1:0] r_start_value, n_start_value;
    logic [VALUE_WIDTH-1:0] r_end_value, n_end_value;
    logic                   r_prefix_bad, n_prefix_bad;
    logic                   r_comma_seen, n_comma_seen;
    logic                   r_start_digits_seen, n_start_digits_seen;
    logic                   r_start_bad, n_start_bad;
    logic                   r_end_digits_seen, n_end_digits_seen;
    logic                   r_end_bad, n_end_bad;

    logic [brhp_pkg::CHAR_WIDTH-1:0] w_ch;
    logic [brhp_pkg::CHAR_WIDTH-1:0] w_digit_full;
    logic [3:0]                      w_digit;
    logic                            w_is_digit;
    logic [VALUE_WIDTH-1:0]          w_start_acc, w_end_acc;
    logic                            w_start_ovf, w_end_ovf;
    logic                            w_empty;

    // character classification
    assign w_ch         = i_word.char_byte;
    assign w_is_digit   = (w_ch >= brhp_pkg::CHAR_ZERO) && (w_ch <= brhp_pkg::CHAR_NINE);
    assign w_digit_full = w_ch - brhp_pkg::CHAR_ZERO;
    assign w_digit      = w_digit_full[3:0];

    // one accumulator per number field
    brhp_dec_acc #(.VALUE_WIDTH(VALUE_WIDTH)) u_start_acc (
        .i_value (r_start_value),
        .i_digit (w_digit),
        .o_value (w_start_acc),
        .o_ovf   (w_start_ovf)
    );

    brhp_dec_acc #(.VALUE_WIDTH(VALUE_WIDTH)) u_end_acc (
        .i_value (r_end_value),
        .i_digit (w_digit),
        .o_value (w_end_acc),
        .o_ovf   (w_end_ovf)
    );

    // next state for one character
    always_comb begin
        n_phase             = r_phase;
        n_prefix_index      = r_prefix_index;
        n_start_value       = r_start_value;
        n_end_value         = r_end_value;
        n_prefix_bad        = r_prefix_bad;
        n_comma_seen        = r_comma_seen;
        n_start_digits_seen = r_start_digits_seen;
        n_start_bad         = r_start_bad;
        n_end_digits_seen   = r_end_digits_seen;
        n_end_bad           = r_end_bad;
        if (i_word.byte_present) begin
            unique case (r_phase)
                PH_PREFIX: begin
                    if (!r_prefix_bad) begin
                        if ((r_prefix_index < brhp_pkg::PREFIX_LEN) &&
                            (w_ch == brhp_pkg::prefix_char(r_prefix_index))) begin
                            n_prefix_index = r_prefix_index + 3'd1;
                            if (r_prefix_index == brhp_pkg::PREFIX_LEN - 3'd1) begin
                                n_phase = PH_START;
                            end
                        end else begin
                            n_prefix_bad = 1'b1;
                        end
                    end
                end
                PH_START: begin
                    if (w_ch == brhp_pkg::CHAR_COMMA) begin
                        n_comma_seen = 1'b1;
                        n_start_bad  = 1'b1;
                    end else if (w_ch == brhp_pkg::CHAR_DASH) begin
                        n_phase = PH_END;
                    end else if (w_is_digit) begin
                        n_start_digits_seen = 1'b1;
                        if (!r_start_bad) begin
                            if (w_start_ovf) begin
                                n_start_bad = 1'b1;
                            end else begin
                                n_start_value = w_start_acc;
                            end
                        end
                    end else begin
                        n_start_bad = 1'b1;
                    end
                end
                PH_END: begin
                    if (w_ch == brhp_pkg::CHAR_COMMA) begin
                        n_comma_seen = 1'b1;
                        n_end_bad    = 1'b1;
                    end else if (w_is_digit) begin
                        n_end_digits_seen = 1'b1;
                        if (!r_end_bad) begin
                            if (w_end_ovf) begin
                                n_end_bad = 1'b1;
                            end else begin
                                n_end_value = w_end_acc;
                            end
                        end
                    end else begin
                        n_end_bad = 1'b1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // header with no character at all
    assign w_empty = (r_phase == PH_PREFIX) && (r_prefix_index == 3'd0) &&
                     !r_prefix_bad && !i_word.byte_present;

    // prioritized verdict on the state after this character
    always_comb begin
        o_verdict.status      = brhp_pkg::ST_INVALID;
        o_verdict.detail      = brhp_pkg::DT_OK;
        o_verdict.end_present = 1'b0;
        o_range_start         = '0;
        o_range_end           = '0;
        if (w_empty) begin
            o_verdict.status = brhp_pkg::ST_MISSING;
            o_verdict.detail = brhp_pkg::DT_EMPTY;
        end else if (n_phase == PH_PREFIX) begin
            o_verdict.detail = brhp_pkg::DT_NOT_BYTES;
        end else if (n_comma_seen) begin
            o_verdict.detail = brhp_pkg::DT_MULTIPLE;
        end else if (n_phase != PH_END) begin
            o_verdict.detail = brhp_pkg::DT_NO_DASH;
        end else if (!n_start_digits_seen && !n_start_bad) begin
            o_verdict.detail = brhp_pkg::DT_SUFFIX;
        end else if (n_start_bad) begin
            o_verdict.detail = brhp_pkg::DT_BAD_START;
        end else if (n_end_bad) begin
            o_verdict.detail = brhp_pkg::DT_BAD_END;
        end else if (n_end_digits_seen && (n_end_value < n_start_value)) begin
            o_verdict.detail = brhp_pkg::DT_END_LT;
        end else begin
            o_verdict.status      = brhp_pkg::ST_VALID;
            o_verdict.detail      = brhp_pkg::DT_OK;
            o_verdict.end_present = n_end_digits_seen;
            o_range_start         = n_start_value;
            if (n_end_digits_seen) begin
                o_range_end = n_end_value;
            end
        end
    end

    // parser state; last word returns it to the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.last)) begin
            r_phase             <= PH_PREFIX;
            r_prefix_index      <= 3'd0;
            r_start_value       <= '0;
            r_end_value         <= '0;
            r_prefix_bad        <= 1'b0;
            r_comma_seen        <= 1'b0;
            r_start_digits_seen <= 1'b0;
            r_start_bad         <= 1'b0;
            r_end_digits_seen   <= 1'b0;
            r_end_bad           <= 1'b0;
        end else if (i_step) begin
            r_phase             <= n_phase;
            r_prefix_index      <= n_prefix_index;
            r_start_value       <= n_start_value;
            r_end_value         <= n_end_value;
            r_prefix_bad        <= n_prefix_bad;
            r_comma_seen        <= n_comma_seen;
            r_start_digits_seen <= n_start_digits_seen;
            r_start_bad         <= n_start_bad;
            r_end_digits_seen   <= n_end_digits_seen;
            r_end_bad           <= n_end_bad;
        end
    end

endmodule

[rtl/byte_range_header_parser_unit.sv]
// byte range header parser: top level with input and result registers
// a word accepted into the input register then steps the parser; a last word's
//   result is loaded into the result register in that step and shows on o_valid
// throughput: one word per cycle, set by the single parser step per cycle
// a stalled result blocks only a last word; earlier words keep flowing
// reset: synchronous active-low i_rst_n empties both registers and the parser

module byte_range_header_parser_unit #(
    parameter int VALUE_WIDTH = brhp_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_byte_present,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_detail,
    output logic [63:0] o_range_start,
    output logic [63:0] o_range_end,
    output logic        o_end_present
);

    localparam int OutW = brhp_pkg::OUT_VALUE_WIDTH;

    logic                   r_in_valid;
    brhp_pkg::t_in_word     r_in_word;
    logic                   w_advance;
    logic                   w_step;
    brhp_pkg::t_verdict     w_verdict;
    logic [VALUE_WIDTH-1:0] w_range_start, w_range_end;
    logic                   w_load;

    logic                   r_out_valid;
    brhp_pkg::t_verdict     r_out_verdict;
    logic [OutW-1:0]        r_out_start, r_out_end;

    // a last word can only move on when the result register is free
    assign w_advance = !(r_in_word.last && r_out_valid && i_stall);
    assign w_step    = r_in_valid && w_advance;
    assign w_load    = w_step && r_in_word.last;
    assign o_stall   = r_in_valid && !w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_in_word.char_byte    <= i_char_byte;
            r_in_word.byte_present <= i_byte_present;
            r_in_word.last         <= i_last;
        end
    end

    brhp_parse_core #(.VALUE_WIDTH(VALUE_WIDTH)) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_word        (r_in_word),
        .o_verdict     (w_verdict),
        .o_range_start (w_range_start),
        .o_range_end   (w_range_end)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_verdict <= w_verdict;
            r_out_start   <= OutW'(w_range_start);
            r_out_end     <= OutW'(w_range_end);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_verdict.status;
    assign o_detail      = r_out_verdict.detail;
    assign o_end_present = r_out_verdict.end_present;
    assign o_range_start = r_out_start;
    assign o_range_end   = r_out_end;

endmodule

[rtl/brhp_checker.sv]
// port-level checks for the byte range header parser, bound to the top level
module brhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [3:0]  o_detail,
    input logic [63:0] o_range_start,
    input logic [63:0] o_range_end,
    input logic        o_end_present
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_detail) &&
        $stable(o_range_start) && $stable(o_range_end) && $stable(o_end_present))
        else $error("result changed while stalled");

    // valid status always pairs with ok detail
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == brhp_pkg::ST_VALID) |-> (o_detail == brhp_pkg::DT_OK))
        else $error("valid status with error detail");

    // non-valid results carry zero offsets
    a_zero_offsets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != brhp_pkg::ST_VALID) |->
        (o_range_start == 64'd0) && (o_range_end == 64'd0) && !o_end_present)
        else $error("offsets on a rejected header");

    // missing only for an empty header
    a_missing_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == brhp_pkg::ST_MISSING) |-> (o_detail == brhp_pkg::DT_EMPTY))
        else $error("missing status with wrong detail");

    // an accepted closed range is ordered
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == brhp_pkg::ST_VALID) && o_end_present |->
        (o_range_end >= o_range_start))
        else $error("closed range with end below start");

endmodule

bind byte_range_header_parser_unit brhp_checker u_brhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_detail      (o_detail),
    .o_range_start (o_range_start),
    .o_range_end   (o_range_end),
    .o_end_present (o_end_present)
);
